// File: hdl/ps2_mouse_cursor_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Short forms for the concurrent checks of the tracker core.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PS2MCT_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PS2MCT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared widths, reset values, register indexes and bundle types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2mct_pkg;

  localparam int unsigned COORD_BITS_DEF = 13;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SENS_W     = 10;
  localparam int unsigned SCREEN_W   = 13;
  localparam int unsigned SPRITE_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned FLAG_W     = 5;

  localparam int unsigned SENS_RST  = 100;
  localparam int unsigned SCR_W_RST = 1024;
  localparam int unsigned SCR_H_RST = 768;
  localparam int unsigned SPR_RST   = 0;
  localparam int          CURSOR_RST_X = 512;
  localparam int          CURSOR_RST_Y = 384;

  // Delta scaling: byte * sensitivity, then divide by 100 via reciprocal.
  // Magnitude stays below 2^17, and 2^17 * 84 < 2^24 keeps the quotient exact.
  localparam int unsigned PROD_W    = 19;
  localparam int unsigned MAG_W     = 17;
  localparam int unsigned RECIP_W   = 18;
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned QUO_W     = 11;
  localparam int unsigned DELTA_W   = 12;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 18'd167773;

  // Status byte bit positions.
  localparam int unsigned BIT_LEFT   = 0;
  localparam int unsigned BIT_RIGHT  = 1;
  localparam int unsigned BIT_MIDDLE = 2;
  localparam int unsigned BIT_OVF_X  = 6;
  localparam int unsigned BIT_OVF_Y  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS  = 3'd0,
    CFG_SCR_W = 3'd1,
    CFG_SCR_H = 3'd2,
    CFG_SPR_W = 3'd3,
    CFG_SPR_H = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_e;

  typedef struct packed {
    logic [SENS_W-1:0]   sens;
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;
    logic [SPRITE_W-1:0] spr_w;
    logic [SPRITE_W-1:0] spr_h;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy;
  } pkt_t;

  typedef struct packed {
    logic [BYTE_W-1:0]         status;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } dlt_t;

endpackage

// File: hdl/ps2mct_cfg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker configuration registers
// Write-only register file for sensitivity, screen and cursor sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2mct_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ps2mct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ps2mct_pkg::cfg_t                 cfg_o
);
  import ps2mct_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sens  <= SENS_W'(SENS_RST);
      cfg_q.scr_w <= SCREEN_W'(SCR_W_RST);
      cfg_q.scr_h <= SCREEN_W'(SCR_H_RST);
      cfg_q.spr_w <= SPRITE_W'(SPR_RST);
      cfg_q.spr_h <= SPRITE_W'(SPR_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SENS:  cfg_q.sens  <= cfg_data_i[SENS_W-1:0];
        CFG_SCR_W: cfg_q.scr_w <= cfg_data_i[SCREEN_W-1:0];
        CFG_SCR_H: cfg_q.scr_h <= cfg_data_i[SCREEN_W-1:0];
        CFG_SPR_W: cfg_q.spr_w <= cfg_data_i[SPRITE_W-1:0];
        CFG_SPR_H: cfg_q.spr_h <= cfg_data_i[SPRITE_W-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/ps2mct_pkt_asm.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker packet assembler
// Groups incoming bytes into status / X / Y packets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2mct_pkt_asm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         byte_valid_i,
  output logic                         byte_ready_o,
  input  logic [ps2mct_pkg::BYTE_W-1:0] byte_i,
  output logic                         pkt_valid_o,
  input  logic                         pkt_ready_i,
  output ps2mct_pkg::pkt_t             pkt_o
);
  import ps2mct_pkg::*;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] status_q;
  logic [BYTE_W-1:0] dx_q;
  logic              pkt_valid_q, pkt_valid_d;
  pkt_t              pkt_q;
  logic              accept;
  logic              take_status, take_dx, emit;

  assign byte_ready_o = !pkt_valid_q || pkt_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_STATUS: phase_d = PH_DX;
        PH_DX:     phase_d = PH_DY;
        default:   phase_d = PH_STATUS;
      endcase
    end
  end

  // Phase decode; the unreachable fourth code acts as the Y byte.
  always_comb begin
    take_status = 1'b0;
    take_dx     = 1'b0;
    emit        = 1'b0;
    unique case (phase_q)
      PH_STATUS: take_status = accept;
      PH_DX:     take_dx     = accept;
      default:   emit        = accept;
    endcase
  end

  always_comb begin
    pkt_valid_d = pkt_valid_q;
    if (emit) begin
      pkt_valid_d = 1'b1;
    end else if (pkt_ready_i) begin
      pkt_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STATUS;
      pkt_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pkt_valid_q <= pkt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_status) begin
      status_q <= byte_i;
    end
    if (take_dx) begin
      dx_q <= byte_i;
    end
    if (emit) begin
      pkt_q.status <= status_q;
      pkt_q.dx     <= dx_q;
      pkt_q.dy     <= byte_i;
    end
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

endmodule

// File: hdl/ps2mct_scale.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker delta scaler
// Two-stage scale of both deltas: multiply by sensitivity, divide by 100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2mct_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ps2mct_pkg::SENS_W-1:0] sens_i,
  input  logic                         pkt_valid_i,
  output logic                         pkt_ready_o,
  input  ps2mct_pkg::pkt_t             pkt_i,
  output logic                         dlt_valid_o,
  input  logic                         dlt_ready_i,
  output ps2mct_pkg::dlt_t             dlt_o
);
  import ps2mct_pkg::*;

  localparam int unsigned LANES  = 2;
  localparam int unsigned FULL_W = MAG_W + RECIP_W;

  logic              a_valid_q, b_valid_q;
  logic              a_ready, b_ready;
  logic [BYTE_W-1:0] a_status_q;
  logic              a_neg_q [LANES];
  logic [MAG_W-1:0]  a_mag_q [LANES];
  dlt_t              b_q;

  logic [BYTE_W-1:0]        lane_byte [LANES];
  logic signed [PROD_W-1:0] sens_ext;
  logic signed [PROD_W-1:0] byte_ext  [LANES];
  logic signed [PROD_W-1:0] prod      [LANES];
  logic [PROD_W-1:0]        prod_abs  [LANES];
  logic [FULL_W-1:0]        recip_mul [LANES];
  logic [DELTA_W-1:0]       quo_ext   [LANES];
  logic [DELTA_W-1:0]       delta     [LANES];

  assign b_ready     = !b_valid_q || dlt_ready_i;
  assign a_ready     = !a_valid_q || b_ready;
  assign pkt_ready_o = a_ready;

  assign lane_byte[0] = pkt_i.dx;
  assign lane_byte[1] = pkt_i.dy;
  assign sens_ext     = signed'(PROD_W'(sens_i));

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign byte_ext[l]  = PROD_W'(signed'(lane_byte[l]));
    assign prod[l]      = byte_ext[l] * sens_ext;
    assign prod_abs[l]  = prod[l][PROD_W-1] ? PROD_W'(-prod[l]) : PROD_W'(prod[l]);
    // Reciprocal multiply, keep the integer part of mag / 100.
    assign recip_mul[l] = FULL_W'(a_mag_q[l]) * FULL_W'(DIV_RECIP);
    assign quo_ext[l]   = DELTA_W'(recip_mul[l][DIV_SHIFT +: QUO_W]);
    assign delta[l]     = a_neg_q[l] ? (DELTA_W'(0) - quo_ext[l]) : quo_ext[l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= pkt_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && pkt_valid_i) begin
      a_status_q <= pkt_i.status;
      for (int l = 0; l < LANES; l++) begin
        a_neg_q[l] <= prod[l][PROD_W-1];
        a_mag_q[l] <= prod_abs[l][MAG_W-1:0];
      end
    end
    if (b_ready && a_valid_q) begin
      b_q.status <= a_status_q;
      b_q.dx     <= signed'(delta[0]);
      b_q.dy     <= signed'(delta[1]);
    end
  end

  assign dlt_valid_o = b_valid_q;
  assign dlt_o       = b_q;

endmodule

// File: hdl/ps2mct_track.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker position update
// Applies scaled deltas, clamps to the screen and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2mct_track #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ps2mct_pkg::cfg_t              cfg_i,
  input  logic                          dlt_valid_i,
  output logic                          dlt_ready_o,
  input  ps2mct_pkg::dlt_t              dlt_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]  pos_x_o,
  output logic signed [COORD_BITS-1:0]  pos_y_o,
  output logic [ps2mct_pkg::FLAG_W-1:0] flags_o
);
  import ps2mct_pkg::*;

  localparam int unsigned CALC_W = ((COORD_BITS > 14) ? COORD_BITS : 14) + 1;
  localparam int COORD_MAX_I = (2 ** (COORD_BITS - 1)) - 1;
  localparam int RST_X_I = (CURSOR_RST_X > COORD_MAX_I) ? COORD_MAX_I : CURSOR_RST_X;
  localparam int RST_Y_I = (CURSOR_RST_Y > COORD_MAX_I) ? COORD_MAX_I : CURSOR_RST_Y;
  localparam logic signed [CALC_W-1:0]     COORD_MAX_C = CALC_W'(COORD_MAX_I);
  localparam logic signed [COORD_BITS-1:0] RST_X = COORD_BITS'(RST_X_I);
  localparam logic signed [COORD_BITS-1:0] RST_Y = COORD_BITS'(RST_Y_I);

  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [FLAG_W-1:0]            flags_q, flags_d;
  logic                         out_valid_q;
  logic                         load;
  logic signed [CALC_W-1:0]     lim_x, lim_y, upper_x, upper_y;
  logic signed [CALC_W-1:0]     sum_x, sum_y, pos_x, pos_y;

  function automatic logic signed [CALC_W-1:0] clamp(
    input logic signed [CALC_W-1:0] v,
    input logic signed [CALC_W-1:0] upper
  );
    logic signed [CALC_W-1:0] lo;
    lo = (v < 0) ? CALC_W'(0) : v;
    return (lo > upper) ? upper : lo;
  endfunction

  assign dlt_ready_o = !out_valid_q || out_ready_i;
  assign load        = dlt_valid_i && dlt_ready_o;

  // Upper bound: screen minus (sprite + 1), capped to the coordinate range.
  assign lim_x   = CALC_W'(cfg_i.scr_w) - CALC_W'(cfg_i.spr_w) - CALC_W'(1);
  assign lim_y   = CALC_W'(cfg_i.scr_h) - CALC_W'(cfg_i.spr_h) - CALC_W'(1);
  assign upper_x = (lim_x > COORD_MAX_C) ? COORD_MAX_C : lim_x;
  assign upper_y = (lim_y > COORD_MAX_C) ? COORD_MAX_C : lim_y;

  assign sum_x = CALC_W'(cur_x_q) + CALC_W'(dlt_i.dx);
  assign sum_y = CALC_W'(cur_y_q) - CALC_W'(dlt_i.dy);
  assign pos_x = clamp(sum_x, upper_x);
  assign pos_y = clamp(sum_y, upper_y);

  assign cur_x_d = pos_x[COORD_BITS-1:0];
  assign cur_y_d = pos_y[COORD_BITS-1:0];
  assign flags_d = {dlt_i.status[BIT_OVF_Y], dlt_i.status[BIT_OVF_X],
                    dlt_i.status[BIT_MIDDLE], dlt_i.status[BIT_RIGHT],
                    dlt_i.status[BIT_LEFT]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= RST_X;
      cur_y_q     <= RST_Y;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_x_q     <= cur_x_d;
        cur_y_q     <= cur_y_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_x_q <= cur_x_d;
      out_y_q <= cur_y_d;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign flags_o     = flags_q;

endmodule

// File: hdl/ps2_mouse_cursor_tracker_core.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker core
// Takes one mouse byte per request on the input stream and groups bytes
// into three-byte packets: status, X delta, Y delta. Each delta is scaled by
// sensitivity_percent / 100 (truncated toward zero); X is added to and Y
// subtracted from the cursor, and each coordinate is clamped to zero and then
// to screen size minus (cursor size + 1), so a screen no larger than the cursor
// drives the coordinate negative. One result request leaves per packet,
// carrying both coordinates, the three buttons and the two overflow flags.
// The block takes a byte every cycle while the pipeline is not backed up; a
// packet's result passes through the assembler register, which loads on the
// edge that takes its Y byte, then the product, quotient and position
// registers. Input ready drops only once a stalled output has backed the
// pipeline up to the assembler. The cursor resets to 512, 384.
// Configuration registers: 0 sensitivity, 1 screen width, 2 screen height,
// 3 cursor width, 4 cursor height; other indexes are ignored. Write them only
// while no packet is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ps2_mouse_cursor_tracker_core_macros.svh"

module ps2_mouse_cursor_tracker_core #(
  parameter int unsigned COORD_BITS = ps2mct_pkg::COORD_BITS_DEF,
  localparam int unsigned TDATA_W = ((2 * COORD_BITS + ps2mct_pkg::FLAG_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream: data_byte
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ps2mct_pkg::BYTE_W-1:0]     s_axis_tdata,
  // output stream, from bit 0 up: pos_x, pos_y, button_left, button_right,
  // button_middle, overflow_x, overflow_y, zero padding
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [TDATA_W-1:0]               m_axis_tdata,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ps2mct_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ps2mct_pkg::*;

  cfg_t                         cfg;
  pkt_t                         pkt;
  dlt_t                         dlt;
  logic                         pkt_valid, pkt_ready;
  logic                         dlt_valid, dlt_ready;
  logic signed [COORD_BITS-1:0] out_pos_x, out_pos_y;
  logic [FLAG_W-1:0]            out_flags;

  // Hold the register file.
  ps2mct_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Count bytes into packets; only the Y byte advances a packet downstream.
  ps2mct_pkt_asm u_pkt_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .pkt_valid_o  (pkt_valid),
    .pkt_ready_i  (pkt_ready),
    .pkt_o        (pkt)
  );

  // Scale both deltas: product stage, then reciprocal divide stage.
  ps2mct_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sens_i      (cfg.sens),
    .pkt_valid_i (pkt_valid),
    .pkt_ready_o (pkt_ready),
    .pkt_i       (pkt),
    .dlt_valid_o (dlt_valid),
    .dlt_ready_i (dlt_ready),
    .dlt_o       (dlt)
  );

  // Advance the cursor, clamp, and hold the result for the output stream.
  ps2mct_track #(
    .COORD_BITS (COORD_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .dlt_valid_i (dlt_valid),
    .dlt_ready_o (dlt_ready),
    .dlt_i       (dlt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pos_x_o     (out_pos_x),
    .pos_y_o     (out_pos_y),
    .flags_o     (out_flags)
  );

  // Pack the result, pos_x in the lowest bits.
  assign m_axis_tdata = TDATA_W'({out_flags, out_pos_y, out_pos_x});

  // A negative coordinate is only legal when the cursor is at least as wide (or tall) as the screen.
  `PS2MCT_ASSERT(a_pos_x_floor, m_axis_tvalid, !out_pos_x[COORD_BITS-1] || (cfg.scr_w <= 13'(cfg.spr_w)), "pos_x negative on a screen wider than the cursor")
  `PS2MCT_ASSERT(a_pos_y_floor, m_axis_tvalid, !out_pos_y[COORD_BITS-1] || (cfg.scr_h <= 13'(cfg.spr_h)), "pos_y negative on a screen taller than the cursor")
  // A result only follows a scaled packet; nothing may bypass the pipeline.
  `PS2MCT_ASSERT_NXT(a_no_early_result, !m_axis_tvalid && !dlt_valid, !m_axis_tvalid, "result appeared without a scaled packet")

endmodule

// File: test/ps2_mouse_cursor_tracker_core_test.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker core testbench
// Streams mouse bytes into the tracker and predicts every cursor report from
// its own copy of the packet assembler, delta scaling and edge clamps. Each
// report is checked field by field in order. Runs directed packets at the
// extremes, then random packets with stray bytes, under several register
// settings and handshake idle mixes, including a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int unsigned TRK_COORD_BITS = ps2mct_pkg::COORD_BITS_DEF;
localparam int unsigned TRK_REPORT_W =
    ((2 * TRK_COORD_BITS + ps2mct_pkg::FLAG_W + 7) / 8) * 8;
localparam int TRK_PERCENT = 100;

typedef struct {
  logic signed [TRK_COORD_BITS-1:0] pos_x;
  logic signed [TRK_COORD_BITS-1:0] pos_y;
  logic                             left;
  logic                             right;
  logic                             middle;
  logic                             ovf_x;
  logic                             ovf_y;
} cursor_report_t;

// Cursor predictor and report checker.
class cursor_tracker_scoreboard;
  logic [ps2mct_pkg::SENS_W-1:0]   sens;
  logic [ps2mct_pkg::SCREEN_W-1:0] scr_w;
  logic [ps2mct_pkg::SCREEN_W-1:0] scr_h;
  logic [ps2mct_pkg::SPRITE_W-1:0] spr_w;
  logic [ps2mct_pkg::SPRITE_W-1:0] spr_h;

  ps2mct_pkg::phase_e              phase;
  logic [ps2mct_pkg::BYTE_W-1:0]   status_q;
  logic [ps2mct_pkg::BYTE_W-1:0]   dx_q;
  int                              cur_x;
  int                              cur_y;

  cursor_report_t                  reports_due[$];
  int                              errors;

  function new();
    errors = 0;
    sens   = ps2mct_pkg::SENS_RST;
    scr_w  = ps2mct_pkg::SCR_W_RST;
    scr_h  = ps2mct_pkg::SCR_H_RST;
    spr_w  = ps2mct_pkg::SPR_RST;
    spr_h  = ps2mct_pkg::SPR_RST;
    phase  = ps2mct_pkg::PH_STATUS;
    status_q = '0;
    dx_q     = '0;
    cur_x  = sat_top(ps2mct_pkg::CURSOR_RST_X);
    cur_y  = sat_top(ps2mct_pkg::CURSOR_RST_Y);
  endfunction

  function int sat_top(int v);
    int top;
    top = (1 << (TRK_COORD_BITS - 1)) - 1;
    return (v > top) ? top : v;
  endfunction

  function void write_reg(logic [ps2mct_pkg::CFG_IDX_W-1:0] idx,
                          logic [ps2mct_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ps2mct_pkg::CFG_SENS:  sens  = data[ps2mct_pkg::SENS_W-1:0];
      ps2mct_pkg::CFG_SCR_W: scr_w = data[ps2mct_pkg::SCREEN_W-1:0];
      ps2mct_pkg::CFG_SCR_H: scr_h = data[ps2mct_pkg::SCREEN_W-1:0];
      ps2mct_pkg::CFG_SPR_W: spr_w = data[ps2mct_pkg::SPRITE_W-1:0];
      ps2mct_pkg::CFG_SPR_H: spr_h = data[ps2mct_pkg::SPRITE_W-1:0];
      default: ;
    endcase
  endfunction

  // Sign-extend the delta, scale, truncate toward zero.
  function int scaled(logic [ps2mct_pkg::BYTE_W-1:0] b);
    return (int'($signed(b)) * int'(sens)) / TRK_PERCENT;
  endfunction

  // Floor at zero first, then the far edge, so a tiny screen goes negative.
  function int clamped(int pos, int screen, int sprite);
    int upper;
    upper = sat_top(screen - (sprite + 1));
    if (pos < 0) pos = 0;
    if (pos > upper) pos = upper;
    return pos;
  endfunction

  function void note_byte(logic [ps2mct_pkg::BYTE_W-1:0] b);
    cursor_report_t rep;
    case (phase)
      ps2mct_pkg::PH_STATUS: begin
        status_q = b;
        phase    = ps2mct_pkg::PH_DX;
      end
      ps2mct_pkg::PH_DX: begin
        dx_q  = b;
        phase = ps2mct_pkg::PH_DY;
      end
      default: begin
        cur_x = clamped(cur_x + scaled(dx_q), int'(scr_w), int'(spr_w));
        cur_y = clamped(cur_y - scaled(b), int'(scr_h), int'(spr_h));
        phase = ps2mct_pkg::PH_STATUS;
        rep.pos_x  = cur_x[TRK_COORD_BITS-1:0];
        rep.pos_y  = cur_y[TRK_COORD_BITS-1:0];
        rep.left   = status_q[ps2mct_pkg::BIT_LEFT];
        rep.right  = status_q[ps2mct_pkg::BIT_RIGHT];
        rep.middle = status_q[ps2mct_pkg::BIT_MIDDLE];
        rep.ovf_x  = status_q[ps2mct_pkg::BIT_OVF_X];
        rep.ovf_y  = status_q[ps2mct_pkg::BIT_OVF_Y];
        reports_due.push_back(rep);
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_report(logic [TRK_REPORT_W-1:0] word);
    cursor_report_t exp_rep;
    cursor_report_t got;
    int unsigned    b;
    b = 2 * TRK_COORD_BITS;
    got.pos_x  = word[TRK_COORD_BITS-1:0];
    got.pos_y  = word[2*TRK_COORD_BITS-1:TRK_COORD_BITS];
    got.left   = word[b];
    got.right  = word[b+1];
    got.middle = word[b+2];
    got.ovf_x  = word[b+3];
    got.ovf_y  = word[b+4];
    if (reports_due.size() == 0) begin
      report_mismatch($sformatf("report with none due: x=%0d y=%0d", got.pos_x, got.pos_y));
      return;
    end
    exp_rep = reports_due.pop_front();
    if (got.pos_x !== exp_rep.pos_x)
      report_mismatch($sformatf("pos_x got %0d want %0d", got.pos_x, exp_rep.pos_x));
    if (got.pos_y !== exp_rep.pos_y)
      report_mismatch($sformatf("pos_y got %0d want %0d", got.pos_y, exp_rep.pos_y));
    if (got.left !== exp_rep.left)
      report_mismatch($sformatf("button_left got %b want %b", got.left, exp_rep.left));
    if (got.right !== exp_rep.right)
      report_mismatch($sformatf("button_right got %b want %b", got.right, exp_rep.right));
    if (got.middle !== exp_rep.middle)
      report_mismatch($sformatf("button_middle got %b want %b", got.middle, exp_rep.middle));
    if (got.ovf_x !== exp_rep.ovf_x)
      report_mismatch($sformatf("overflow_x got %b want %b", got.ovf_x, exp_rep.ovf_x));
    if (got.ovf_y !== exp_rep.ovf_y)
      report_mismatch($sformatf("overflow_y got %b want %b", got.ovf_y, exp_rep.ovf_y));
  endtask

  function int pending();
    return reports_due.size();
  endfunction
endclass

module ps2_mouse_cursor_tracker_core_test;
  import ps2mct_pkg::*;

  // Settle margin after the last report due, also covering partial packets.
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_BYTES    = 250;
  localparam int RANDOM_PHASES  = 8;
  localparam int CYCLE_LIMIT    = 300000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata;   // data_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // pos_x, pos_y, button_left, button_right, button_middle, overflow_x,
  // overflow_y, zero padding (from bit 0 up)
  logic [TRK_REPORT_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  cursor_tracker_scoreboard tracker;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_seq;
  int hold_seen;
  int hold_left;
  int cycle_count = 0;
  int bytes_sent;

  ps2_mouse_cursor_tracker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Hard stop: a hung handshake or a lost report ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** ps2_mouse_cursor_tracker_core: FAILED **");
    $finish;
  end

  // Sample both streams at the edge: note every accepted byte, check every
  // accepted report against the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) tracker.check_report(m_axis_tdata);
    end
  end

  // Output side: random stalls, plus a long hold-off whenever the stimulus
  // bumps hold_off_seq. The hold-off is counted here, not in the sender.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 0;
      hold_left     <= 0;
    end else if (hold_off_seq != hold_seen) begin
      hold_seen     <= hold_off_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one byte and hold it until the block takes it. Idle gaps come
  // before the byte; valid stays high across back-to-back requests.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] status,
                             input logic [BYTE_W-1:0] dx,
                             input logic [BYTE_W-1:0] dy);
    send_byte(status);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Drop valid, wait out every report due, then let a partial packet and
  // the pipeline settle before any register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // Program all five registers plus one write to an unused index, which
  // must change nothing.
  task automatic program_settings(input int sens, input int sw, input int sh,
                                  input int pw, input int ph);
    write_reg(CFG_SENS, CFG_DATA_W'(sens));
    write_reg(CFG_SCR_W, CFG_DATA_W'(sw));
    write_reg(CFG_SCR_H, CFG_DATA_W'(sh));
    write_reg(CFG_SPR_W, CFG_DATA_W'(pw));
    write_reg(CFG_SPR_H, CFG_DATA_W'(ph));
    write_reg(CFG_IDX_W'(CFG_SPR_H) + CFG_IDX_W'($urandom_range(1, 3)),
              CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Deltas lean on full-scale moves so the edge clamps get exercised.
  function automatic logic [BYTE_W-1:0] pick_delta();
    case ($urandom_range(7))
      0:       return 8'h7F;
      1:       return 8'h80;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int sens;
    int sw;
    int sh;
    int pw;
    int ph;
    int phase_start;

    tracker        = new();
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_seq   = 0;
    bytes_sent     = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: all status bits set (bit 3 and the sign
    // bits must be ignored), full-scale deltas both ways, zero and -1 moves.
    send_packet(8'hFF, 8'h7F, 8'h80);
    send_packet(8'h00, 8'h80, 8'h7F);
    send_packet(8'h47, 8'h00, 8'h01);
    send_packet(8'h88, 8'hFF, 8'hFF);
    drain();

    // Sensitivity past 1000, screen narrower than the cursor: the far clamp
    // wins and X goes negative, to screen width minus (cursor width + 1).
    program_settings(1023, 0, 1, 255, 0);
    send_packet(8'h05, 8'h7F, 8'h80);
    send_packet(8'hC2, 8'h80, 8'h7F);
    drain();

    // Zero sensitivity freezes the cursor; oversized screen width.
    program_settings(0, 8191, 4096, 0, 255);
    send_packet(8'h03, 8'h7F, 8'h80);
    send_packet(8'h44, 8'h80, 8'h7F);
    drain();

    // Random phases: settings per phase, idle mix rotates through four modes.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: begin sens = 1000; sw = 4096; sh = 4096; pw = 255; ph = 255; end
        1: begin sens = 1;    sw = 1;    sh = 1;    pw = 0;   ph = 0;   end
        2: begin sens = 1023; sw = 8191; sh = 8191; pw = 0;   ph = 0;   end
        default: begin
          sens = $urandom_range(1023);
          sw = ($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(1, 8191);
          sh = ($urandom_range(3) == 0) ? $urandom_range(300) : $urandom_range(1, 8191);
          pw = $urandom_range(255);
          ph = $urandom_range(255);
        end
      endcase
      program_settings(sens, sw, sh, pw, ph);

      case (k % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 56; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 56; end
        default: begin send_idle_pct <= 21; recv_stall_pct <= 21; end
      endcase
      // Hold the output off while bytes keep coming, so the input backs up.
      if (k == 2) hold_off_seq <= hold_off_seq + 1;
      @(posedge clk_i);

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        // A stray byte shifts packet alignment for the rest of the phase.
        if ($urandom_range(19) == 0) send_byte(BYTE_W'($urandom_range(255)));
        else send_packet(BYTE_W'($urandom_range(255)), pick_delta(), pick_delta());
      end
      drain();
    end

    if (tracker.errors == 0) begin
      $display("** ps2_mouse_cursor_tracker_core: PASSED **");
    end else begin
      $display("** ps2_mouse_cursor_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/ps2mct_pkg.sv
hdl/ps2mct_cfg.sv
hdl/ps2mct_pkt_asm.sv
hdl/ps2mct_scale.sv
hdl/ps2mct_track.sv
hdl/ps2_mouse_cursor_tracker_core.sv
test/ps2_mouse_cursor_tracker_core_test.sv
